### hw/rtl/xrds_pkg.sv
// Package for the xorshift128 random draw and shuffle core.
// Holds widths, mode codes, generator constants, shared types and the generator step.
// No dependencies.
`timescale 1ns / 1ps

package xrds_pkg;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 7;
    localparam int PERM_DEPTH = 64;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);
    localparam int MAX_EMIT   = 64;
    localparam int IN_W       = 80;

    localparam logic [MODE_W-1:0] MODE_RAW     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOUNDED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PERM    = 2'd2;

    localparam logic [DATA_W-1:0] SEED_X = 32'd123456789;
    localparam logic [DATA_W-1:0] SEED_Y = 32'd362436069;
    localparam logic [DATA_W-1:0] SEED_Z = 32'd521288629;
    localparam logic [DATA_W-1:0] SEED_W = 32'd88675123;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 19;
    localparam int SHIFT_C = 8;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] w;
    } gen_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic gen_state_t xs_reload(input logic [DATA_W-1:0] seed);
        gen_state_t g;
        g.x = SEED_X;
        g.y = SEED_Y;
        g.z = SEED_Z;
        g.w = SEED_W ^ seed;
        return g;
    endfunction

    function automatic gen_state_t xs_next(input gen_state_t g);
        gen_state_t        r;
        logic [DATA_W-1:0] t;
        t   = g.x ^ (g.x << SHIFT_A);
        r.x = g.y;
        r.y = g.z;
        r.z = g.w;
        r.w = (g.w ^ (g.w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
        return r;
    endfunction

endpackage

### hw/rtl/xrds_divider.sv
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on xrds_pkg for widths and the status struct.
`timescale 1ns / 1ps

module xrds_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [xrds_pkg::DATA_W-1:0] dividend,
    input  logic [xrds_pkg::DATA_W-1:0] divisor,
    output xrds_pkg::div_status_t      status,
    output logic [xrds_pkg::DATA_W-1:0] remainder
);
    import xrds_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[DATA_W-1]};
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DATA_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
                rem_next = DATA_W'(shifted - {1'b0, dsr_reg});
            else
                rem_next = shifted[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");
    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished run");
`endif

endmodule

### hw/rtl/xorshift_random_draw_and_shuffle_core.sv
// Top level of the xorshift128 draw and shuffle core.
// Depends on xrds_pkg and xrds_divider.
`timescale 1ns / 1ps

// Raw word: S_RAW loads the result register once the output is free.
// Bounded draw: the serial remainder unit runs in S_DIV, then S_BEMIT loads the result.
// Permutation: S_FILL fills the table (one write port), then each emitted entry takes a
// remainder unit run plus table read and write-back. Errors: S_ERR loads the result.
// rst_n (async) clears control and loads the generator with its seed-0 words;
// the permutation table is not cleared (it is refilled by every shuffle).
module xorshift_random_draw_and_shuffle_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: seed write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xrds_pkg::DATA_W-1:0]   cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] mode, [33:2] range_low, [65:34] range_high, [72:66] perm_size,
    // [79:73] perm_count
    input  logic [xrds_pkg::IN_W-1:0]     s_tdata,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] value
    output logic [xrds_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tlast,
    // [0] error
    output logic [0:0]                    m_tuser
);
    import xrds_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RAW   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_BEMIT = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_PDRAW = 4'd6;
    localparam logic [3:0] S_PDIV  = 4'd7;
    localparam logic [3:0] S_PEMIT = 4'd8;

    // unpacked input item
    logic [MODE_W-1:0] in_mode;
    logic [DATA_W-1:0] in_low;
    logic [DATA_W-1:0] in_high;
    logic [SIZE_W-1:0] in_size;
    logic [SIZE_W-1:0] in_count;

    assign in_mode  = s_tdata[1:0];
    assign in_low   = s_tdata[33:2];
    assign in_high  = s_tdata[65:34];
    assign in_size  = s_tdata[72:66];
    assign in_count = s_tdata[79:73];

    logic [3:0]         state_reg, state_next;
    gen_state_t         gen_reg, gen_next, gen_step;
    logic [DATA_W-1:0]  lo_reg, lo_next;
    logic [SIZE_W-1:0]  n_reg, n_next;
    logic [SIZE_W-1:0]  k_reg, k_next;
    logic [PERM_AW-1:0] i_reg, i_next;   // fill counter, then shuffle position
    logic [PERM_AW-1:0] j_reg, j_next;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_err_reg, out_err_next;
    logic               out_free;

    // divider hookup
    logic               div_start;
    logic [DATA_W-1:0]  div_divisor;
    div_status_t        div_status;
    logic [DATA_W-1:0]  div_rem;

    // permutation table: one write port, two registered read ports
    logic [PERM_AW-1:0] perm_mem [PERM_DEPTH];
    logic               mem_we;
    logic [PERM_AW-1:0] mem_waddr;
    logic [PERM_AW-1:0] mem_wdata;
    logic               mem_re;
    logic [PERM_AW-1:0] rd_i_reg;
    logic [PERM_AW-1:0] rd_j_reg;

    logic               perm_bad;
    logic               perm_last;

    assign gen_step  = xs_next(gen_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign perm_bad  = (in_size == '0) || (in_size > SIZE_W'(PERM_DEPTH))
                    || (in_count > in_size) || (in_count > SIZE_W'(MAX_EMIT));
    assign perm_last = (({1'b0, i_reg} + 1'b1) == k_reg);

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        lo_next        = lo_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        div_start      = 1'b0;
        div_divisor    = DATA_W'(n_reg - {1'b0, i_reg});
        mem_we         = 1'b0;
        mem_waddr      = i_reg;
        mem_wdata      = i_reg;
        mem_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    gen_next = xs_reload(cfg_data);
                end
                else if (s_tvalid)
                begin
                    lo_next = in_low;
                    n_next  = in_size;
                    k_next  = in_count;
                    i_next  = '0;
                    unique case (in_mode)
                        MODE_RAW:
                            state_next = S_RAW;
                        MODE_BOUNDED:
                        begin
                            if (in_high <= in_low)
                                state_next = S_ERR;
                            else
                            begin
                                gen_next    = gen_step;
                                div_start   = 1'b1;
                                div_divisor = in_high - in_low;
                                state_next  = S_DIV;
                            end
                        end
                        MODE_PERM:
                        begin
                            if (perm_bad)
                                state_next = S_ERR;
                            else if (in_count == '0)
                                state_next = S_IDLE;   // nothing asked for
                            else
                                state_next = S_FILL;
                        end
                        default:
                            state_next = S_ERR;
                    endcase
                end
            end
            S_RAW:
            begin
                if (out_free)
                begin
                    gen_next       = gen_step;
                    out_valid_next = 1'b1;
                    out_data_next  = gen_step.w;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                    state_next = S_BEMIT;
            end
            S_BEMIT:
            begin
                // remainder holds until the next divider start
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = lo_reg + div_rem;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_FILL:
            begin
                mem_we = 1'b1;
                if ({1'b0, i_reg} == (n_reg - 1'b1))
                begin
                    i_next     = '0;
                    state_next = S_PDRAW;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_PDRAW:
            begin
                gen_next   = gen_step;
                div_start  = 1'b1;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_status.done)
                begin
                    // remainder < n - i, so j stays inside the table
                    j_next     = i_reg + div_rem[PERM_AW-1:0];
                    mem_re     = 1'b1;
                    state_next = S_PEMIT;
                end
            end
            S_PEMIT:
            begin
                if (out_free)
                begin
                    // entry i is never read again, so only j is written back
                    mem_we         = 1'b1;
                    mem_waddr      = j_reg;
                    mem_wdata      = rd_i_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = DATA_W'(rd_j_reg);
                    out_last_next  = perm_last;
                    out_err_next   = 1'b0;
                    if (perm_last)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_PDRAW;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= xs_reload('0);
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_i_reg <= perm_mem[i_reg];
            rd_j_reg <= perm_mem[j_next];
        end
    end

    xrds_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (gen_step.w),
        .divisor   (div_divisor),
        .status    (div_status),
        .remainder (div_rem)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_data_reg == '0) && out_last_reg)
        else $error("error item with nonzero value or without last");
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEMIT) |-> (j_reg >= i_reg) && ({1'b0, i_reg} < k_reg))
        else $error("shuffle index out of order");
    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) || (state_reg == S_PDIV)) && !div_status.done
        |-> div_status.busy)
        else $error("waiting on an idle divider");
`endif

endmodule
